/* src/rwla_pkg.sv */
// Package: types, constants and op codes of the reader-writer lock arbiter.
`default_nettype none

package rwla_pkg;

  // Client bound and field widths
  localparam int MAX_CLIENTS = 64;
  localparam int OP_W        = 3;
  localparam int REQ_ID_W    = 16;
  localparam int HOLD_W      = 8;
  localparam int WAIT_W      = 7;

  typedef logic signed [HOLD_W-1:0] hold_t;
  typedef logic [WAIT_W-1:0]        wait_t;
  typedef logic [REQ_ID_W-1:0]      req_id_t;

  localparam hold_t HOLD_MAX = hold_t'(MAX_CLIENTS);
  localparam hold_t HOLD_MIN = hold_t'(-MAX_CLIENTS);
  localparam wait_t WAIT_MAX = wait_t'(MAX_CLIENTS);

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_LOCK_WR = 3'd0,
    OP_LOCK_RD = 3'd1,
    OP_TRY_WR  = 3'd2,
    OP_TRY_RD  = 3'd3,
    OP_UNLOCK  = 3'd4
  } op_e;

  // Input item
  typedef struct packed {
    logic [OP_W-1:0] op;
    req_id_t         requester_id;
  } req_t;

  // Result item
  typedef struct packed {
    logic        granted;
    logic        queued;
    logic        release_writer;
    wait_t       release_readers;
    logic        error;
    hold_t       holders_after;
  } rsp_t;

endpackage

`default_nettype wire

/* src/rwla_in_reg.sv */
// Input register: holds one accepted request until the lock core takes it.
`default_nettype none

module rwla_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rwla_pkg::req_t in_req_i,
  input  wire logic          take_i,
  output logic               valid_o,
  output rwla_pkg::req_t     req_o
);
  import rwla_pkg::*;

  logic valid_q, valid_d;
  req_t req_q;

  // Accept when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load the payload on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

/* src/rwla_core.sv */
// Lock core: holder and waiting counts, owner id, and the per-request decision.
`default_nettype none

module rwla_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rwla_pkg::req_t req_i,
  input  wire logic           step_i,
  output rwla_pkg::rsp_t      rsp_o
);
  import rwla_pkg::*;

  hold_t   holder_q, holder_d;
  wait_t   wwait_q, wwait_d;
  wait_t   rwait_q, rwait_d;
  req_id_t owner_q, owner_d;

  logic  is_owner;
  logic  write_free;
  logic  write_pending;
  hold_t released;
  rsp_t  rsp;

  // Decode lock conditions
  assign is_owner      = (owner_q != '0) && (owner_q == req_i.requester_id);
  assign write_free    = (holder_q == '0) || (holder_q < 0 && is_owner);
  assign write_pending = (wwait_q != '0) || (holder_q < 0);
  assign released      = (holder_q > 0) ? holder_q - hold_t'(1) : holder_q + hold_t'(1);

  // Decide the request and compute the next state
  always_comb begin
    holder_d = holder_q;
    wwait_d  = wwait_q;
    rwait_d  = rwait_q;
    owner_d  = owner_q;
    rsp      = '0;
    unique case (op_e'(req_i.op)) inside
      OP_LOCK_WR, OP_TRY_WR: begin
        if (write_free) begin
          if (holder_q == HOLD_MIN) begin
            rsp.error = 1'b1;
          end else begin
            holder_d    = holder_q - hold_t'(1);
            owner_d     = req_i.requester_id;
            rsp.granted = 1'b1;
          end
        end else if (op_e'(req_i.op) == OP_LOCK_WR) begin
          if (wwait_q >= WAIT_MAX) begin
            rsp.error = 1'b1;
          end else begin
            wwait_d    = wwait_q + wait_t'(1);
            rsp.queued = 1'b1;
          end
        end
      end
      OP_LOCK_RD, OP_TRY_RD: begin
        if (!write_pending) begin
          if (holder_q >= HOLD_MAX) begin
            rsp.error = 1'b1;
          end else begin
            holder_d    = holder_q + hold_t'(1);
            rsp.granted = 1'b1;
          end
        end else if (op_e'(req_i.op) == OP_LOCK_RD) begin
          if (rwait_q >= WAIT_MAX) begin
            rsp.error = 1'b1;
          end else begin
            rwait_d    = rwait_q + wait_t'(1);
            rsp.queued = 1'b1;
          end
        end
      end
      OP_UNLOCK: begin
        if (holder_q == '0) begin
          rsp.error = 1'b1;
        end else begin
          rsp.granted = 1'b1;
          holder_d    = released;
          if (released == '0) begin
            owner_d = '0;
            // Hand off to one writer first, else to all waiting readers
            if (wwait_q != '0) begin
              holder_d           = hold_t'(-1);
              wwait_d            = wwait_q - wait_t'(1);
              rsp.release_writer = 1'b1;
            end else if (rwait_q != '0) begin
              holder_d            = hold_t'({1'b0, rwait_q});
              rsp.release_readers = rwait_q;
              rwait_d             = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    rsp.holders_after = holder_d;
  end

  // Advance the lock state when a request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holder_q <= '0;
      wwait_q  <= '0;
      rwait_q  <= '0;
      owner_q  <= '0;
    end else if (step_i) begin
      holder_q <= holder_d;
      wwait_q  <= wwait_d;
      rwait_q  <= rwait_d;
      owner_q  <= owner_d;
    end
  end

  assign rsp_o = rsp;

endmodule

`default_nettype wire

/* src/rwla_out_reg.sv */
// Result register: holds one result item until the consumer takes it.
`default_nettype none

module rwla_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire rwla_pkg::rsp_t rsp_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rwla_pkg::rsp_t      out_rsp_o
);
  import rwla_pkg::*;

  logic valid_q, valid_d;
  rsp_t rsp_q;

  // Room for a new result when empty or drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      rsp_q <= rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

/* src/reader_writer_lock_arbiter_top.sv */
// Top level of the writer-priority reader-writer lock arbiter.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_ready_o  in_req_i  (rwla_pkg::req_t)
//   out      output     out_valid_o / out_ready_i out_rsp_o (rwla_pkg::rsp_t)
//
// One request per cycle is taken while the output does not stall; the request
// sits in the input register and its result is captured in the result register.
// The single lock-state update between the input register and the result
// register decides one request per cycle while the result register has room.
// Reset clears the holder count, both waiting counts and the owner id.
// A stalled output holds its result; the input register still fills, then
// in_ready_o drops until the result register drains.
`default_nettype none

module reader_writer_lock_arbiter_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire rwla_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rwla_pkg::rsp_t      out_rsp_o
);
  import rwla_pkg::*;

  logic stage_valid;
  req_t stage_req;
  logic out_free;
  logic step;
  rsp_t core_rsp;

  // Move a request into the result register when there is room
  assign step = stage_valid && out_free;

  rwla_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .take_i     (step),
    .valid_o    (stage_valid),
    .req_o      (stage_req)
  );

  rwla_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (stage_req),
    .step_i (step),
    .rsp_o  (core_rsp)
  );

  rwla_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .rsp_i       (core_rsp),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // A writer handoff leaves exactly one writer holding the lock
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.release_writer |->
      out_rsp_o.holders_after == hold_t'(-1) && out_rsp_o.granted)
    else $error("writer handoff with wrong holder count");

  // A reader handoff makes every released reader a holder
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.release_readers != '0 |->
      out_rsp_o.holders_after == hold_t'({1'b0, out_rsp_o.release_readers}))
    else $error("reader handoff count mismatch");

  // An error result changes nothing and grants nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.error |->
      !out_rsp_o.granted && !out_rsp_o.queued && !out_rsp_o.release_writer &&
      out_rsp_o.release_readers == '0)
    else $error("error result carries a grant");

endmodule

`default_nettype wire
